### rtl/rsb_pkg.sv
package rsb_pkg;

  localparam int TIME_BITS = 48;
  localparam int CFG_BITS = 32;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [1:0] CMD_PROBE = 2'd0;
  localparam logic [1:0] CMD_RESTARTED = 2'd1;
  localparam logic [1:0] CMD_REINIT = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_GIVE_UP = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKOFF_START = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKOFF_MAX = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEALTHY_RESET = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FAILURES = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STORM_WINDOW = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STORM_RESTARTS = 3'd5;

  localparam logic [31:0] RST_BACKOFF_START = 32'd1000;
  localparam logic [31:0] RST_BACKOFF_MAX = 32'd60000;
  localparam logic [31:0] RST_HEALTHY_RESET = 32'd30000;
  localparam logic [7:0] RST_FAILURES = 8'd3;
  localparam logic [31:0] RST_STORM_WINDOW = 32'd300000;
  localparam logic [7:0] RST_STORM_RESTARTS = 8'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic healthy;
    logic [TIME_BITS-1:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] restart_count;
  } res_t;

endpackage

### rtl/restart_supervisor_backoff_top.sv
// Channel | Direction | Handshake          | Payload
// evt     | in        | evt_valid/evt_stall | rsb_pkg::evt_t (cmd, healthy, now_ms)
// res     | out       | res_valid/res_stall | rsb_pkg::res_t (action, restart_count)
// cfg     | in        | cfg_we              | cfg_index, cfg_data
// One beat enters per cycle while evt_stall is low.
// The event passes an input register, then the update logic, into the result register.
// A stalled result register holds its beat, and the input register then stalls the event side.
// Synchronous reset restores config, valid flags and supervisor state, not payloads.
module restart_supervisor_backoff_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 evt_valid,
  output logic                                 evt_stall,
  input  rsb_pkg::evt_t                        evt,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output rsb_pkg::res_t                        res,
  input  logic                                 cfg_we,
  input  logic [rsb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rsb_pkg::CFG_BITS-1:0]         cfg_data
);

  localparam int TB = rsb_pkg::TIME_BITS;

  logic [31:0] backoff_start;
  logic [31:0] backoff_max;
  logic [31:0] healthy_reset;
  logic [7:0]  failures_limit;
  logic [31:0] storm_window;
  logic [7:0]  storm_restarts;

  logic          hold_valid;
  rsb_pkg::evt_t hold;
  logic          adv;
  logic          upd;

  logic [7:0]    failure_count, failure_count_next;
  logic [7:0]    restarts, restarts_next;
  logic          gave_up, gave_up_next;
  logic [TB-1:0] healthy_since, healthy_since_next;
  logic [TB-1:0] window_start, window_start_next;
  logic [TB:0]   next_attempt, next_attempt_next;
  logic [31:0]   backoff, backoff_next;
  logic [1:0]    action;

  logic [TB-1:0] hs_eff;
  logic [TB-1:0] health_elapsed;
  logic [TB-1:0] window_elapsed;
  logic [7:0]    fc_inc;
  logic [7:0]    restarts_eff;
  logic [32:0]   doubled;

  assign adv = !res_valid || !res_stall;
  assign upd = hold_valid && adv;
  assign evt_stall = hold_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_start  <= rsb_pkg::RST_BACKOFF_START;
      backoff_max    <= rsb_pkg::RST_BACKOFF_MAX;
      healthy_reset  <= rsb_pkg::RST_HEALTHY_RESET;
      failures_limit <= rsb_pkg::RST_FAILURES;
      storm_window   <= rsb_pkg::RST_STORM_WINDOW;
      storm_restarts <= rsb_pkg::RST_STORM_RESTARTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsb_pkg::CFG_BACKOFF_START:  backoff_start  <= cfg_data;
        rsb_pkg::CFG_BACKOFF_MAX:    backoff_max    <= cfg_data;
        rsb_pkg::CFG_HEALTHY_RESET:  healthy_reset  <= cfg_data;
        rsb_pkg::CFG_FAILURES:       failures_limit <= cfg_data[7:0];
        rsb_pkg::CFG_STORM_WINDOW:   storm_window   <= cfg_data;
        rsb_pkg::CFG_STORM_RESTARTS: storm_restarts <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (evt_valid && !evt_stall) begin
      hold_valid <= 1'b1;
    end else if (adv) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      hold <= evt;
    end
  end

  always_comb begin
    hs_eff = (healthy_since == '0) ? hold.now_ms : healthy_since;
    health_elapsed = (hold.now_ms >= hs_eff) ? hold.now_ms - hs_eff : '0;
    window_elapsed = (hold.now_ms >= window_start) ? hold.now_ms - window_start : '0;
    fc_inc = (failure_count < failures_limit) ? failure_count + 8'd1 : failure_count;
    restarts_eff = restarts;
    doubled = {backoff, 1'b0};

    failure_count_next = failure_count;
    restarts_next = restarts;
    gave_up_next = gave_up;
    healthy_since_next = healthy_since;
    window_start_next = window_start;
    next_attempt_next = next_attempt;
    backoff_next = backoff;
    action = rsb_pkg::ACT_NONE;

    unique case (hold.cmd)
      rsb_pkg::CMD_PROBE: begin
        if (gave_up) begin
          action = rsb_pkg::ACT_GIVE_UP;
        end else if (hold.healthy) begin
          failure_count_next = '0;
          healthy_since_next = hs_eff;
          if (hs_eff != '0 &&
              health_elapsed >= {{(TB-32){1'b0}}, healthy_reset}) begin
            restarts_next = '0;
            backoff_next = backoff_start;
            window_start_next = hold.now_ms;
          end
        end else begin
          healthy_since_next = '0;
          failure_count_next = fc_inc;
          if (fc_inc >= failures_limit) begin
            if (window_elapsed > {{(TB-32){1'b0}}, storm_window}) begin
              window_start_next = hold.now_ms;
              restarts_eff = '0;
            end
            restarts_next = restarts_eff;
            if (restarts_eff >= storm_restarts) begin
              gave_up_next = 1'b1;
              action = rsb_pkg::ACT_GIVE_UP;
            end else if ({1'b0, hold.now_ms} >= next_attempt) begin
              action = rsb_pkg::ACT_RESTART;
            end
          end
        end
      end
      rsb_pkg::CMD_RESTARTED: begin
        if (restarts == '0) begin
          window_start_next = hold.now_ms;
        end
        restarts_next = (restarts != 8'hFF) ? restarts + 8'd1 : restarts;
        failure_count_next = '0;
        healthy_since_next = '0;
        next_attempt_next = {1'b0, hold.now_ms} + {{(TB-31){1'b0}}, backoff};
        backoff_next = (doubled > {1'b0, backoff_max}) ? backoff_max : doubled[31:0];
      end
      rsb_pkg::CMD_REINIT: begin
        failure_count_next = '0;
        restarts_next = '0;
        gave_up_next = 1'b0;
        next_attempt_next = '0;
        backoff_next = backoff_start;
        window_start_next = hold.now_ms;
        healthy_since_next = hold.now_ms;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failure_count <= '0;
      restarts      <= '0;
      gave_up       <= 1'b0;
      healthy_since <= '0;
      window_start  <= '0;
      next_attempt  <= '0;
      backoff       <= rsb_pkg::RST_BACKOFF_START;
    end else if (upd) begin
      failure_count <= failure_count_next;
      restarts      <= restarts_next;
      gave_up       <= gave_up_next;
      healthy_since <= healthy_since_next;
      window_start  <= window_start_next;
      next_attempt  <= next_attempt_next;
      backoff       <= backoff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (upd) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res.action <= action;
      res.restart_count <= restarts_next;
    end
  end

`ifndef SYNTHESIS
  a_give_up_sticks: assert property (@(posedge clk) disable iff (rst)
    (upd && hold.cmd == rsb_pkg::CMD_PROBE && gave_up) |=>
      (res_valid && res.action == rsb_pkg::ACT_GIVE_UP))
    else $error("probe after give-up did not report give-up");

  a_reinit_clears: assert property (@(posedge clk) disable iff (rst)
    (upd && hold.cmd == rsb_pkg::CMD_REINIT) |=>
      (res.restart_count == 8'd0 && res.action == rsb_pkg::ACT_NONE && !gave_up))
    else $error("re-init did not restore the starting state");

  a_restart_counts: assert property (@(posedge clk) disable iff (rst)
    (upd && hold.cmd == rsb_pkg::CMD_RESTARTED) |=> (res.restart_count != 8'd0))
    else $error("restart notice left the restart count at zero");

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (rst)
    evt_stall |-> (hold_valid && res_valid))
    else $error("event side stalled without a held beat");
`endif

endmodule
